@@ design/ufst_pkg.sv @@
// ----------------------------------------------------------------------------
// ufst_pkg
// Shared widths, constants, table word layout and controller/datapath
// command and status types for the spanning tree cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package ufst_pkg;

    // table geometry
    localparam int NUM_VERTICES = 1024;
    localparam int VERTEX_W     = $clog2(NUM_VERTICES);
    localparam int COUNT_W      = 11;
    localparam int RANK_W       = 4;
    localparam int EPOCH_W      = 8;
    localparam int WEIGHT_W     = 16;
    localparam int COST_W       = 32;

    localparam logic [COUNT_W-1:0]  VERTEX_LIMIT  = COUNT_W'(NUM_VERTICES);
    localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RESET = COUNT_W'(1024);
    localparam logic [VERTEX_W-1:0] LAST_VERTEX   = VERTEX_W'(NUM_VERTICES - 1);
    localparam logic [RANK_W-1:0]   RANK_MAX      = '1;
    localparam logic [EPOCH_W-1:0]  EPOCH_MAX     = '1;
    localparam logic [COST_W-1:0]   COST_MAX      = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic [COST_W-1:0]   COST_MIN      = {1'b1, {(COST_W-1){1'b0}}};

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_SEL_VERTEX_COUNT = 1'b0;

    // one word of the merged parent/rank table, tagged with its run epoch
    typedef struct packed {
        logic [EPOCH_W-1:0]  tag;
        logic [RANK_W-1:0]   rank;
        logic [VERTEX_W-1:0] parent;
    } table_word_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE        = 4'd0,
        OP_CAPTURE     = 4'd1,
        OP_NEW_EPOCH   = 4'd2,
        OP_CLEAR_START = 4'd3,
        OP_CLEAR_STEP  = 4'd4,
        OP_START_A     = 4'd5,
        OP_START_B     = 4'd6,
        OP_READ        = 4'd7,
        OP_FIND_NEXT   = 4'd8,
        OP_ROOT_FOUND  = 4'd9,
        OP_COMP_WRITE  = 4'd10,
        OP_UNION       = 4'd11,
        OP_RANK_UP     = 4'd12,
        OP_PUBLISH     = 4'd13
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   side;
    } ctrl_cmd_t;

    typedef struct packed {
        logic new_run;
        logic epoch_full;
        logic clear_last;
        logic range_err;
        logic rd_is_root;
        logic at_root;
        logic rank_up;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/ufst_edge_if.sv @@
// ----------------------------------------------------------------------------
// ufst_edge_if
// Valid/ready channel carrying one weighted edge word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufst_edge_if;
    logic                                valid;
    logic                                ready;
    logic                                new_run;
    logic signed [ufst_pkg::WEIGHT_W-1:0] edge_weight;
    logic [ufst_pkg::VERTEX_W-1:0]       first_vertex;
    logic [ufst_pkg::VERTEX_W-1:0]       second_vertex;

    modport source (
        output valid, new_run, edge_weight, first_vertex, second_vertex,
        input  ready
    );

    modport sink (
        input  valid, new_run, edge_weight, first_vertex, second_vertex,
        output ready
    );
endinterface

`default_nettype wire

@@ design/ufst_result_if.sv @@
// ----------------------------------------------------------------------------
// ufst_result_if
// Valid/ready channel carrying one result word per edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ufst_result_if;
    logic                               valid;
    logic                               ready;
    logic                               edge_taken;
    logic signed [ufst_pkg::COST_W-1:0] total_cost;
    logic                               range_error;

    modport source (
        output valid, edge_taken, total_cost, range_error,
        input  ready
    );

    modport sink (
        input  valid, edge_taken, total_cost, range_error,
        output ready
    );
endinterface

`default_nettype wire

@@ design/ufst_ctrl.sv @@
// ----------------------------------------------------------------------------
// ufst_ctrl
// Sequencer for one edge: run init, range check, find with path
// compression for each endpoint, union by rank, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ufst_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire ufst_pkg::dp_status_t   status,
    output ufst_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [11:0] {
        S_BOOT_CLEAR = 12'b0000_0000_0001,
        S_IDLE       = 12'b0000_0000_0010,
        S_INIT       = 12'b0000_0000_0100,
        S_RUN_CLEAR  = 12'b0000_0000_1000,
        S_CHECK      = 12'b0000_0001_0000,
        S_FIND_RD    = 12'b0000_0010_0000,
        S_FIND_DATA  = 12'b0000_0100_0000,
        S_COMP_RD    = 12'b0000_1000_0000,
        S_COMP_DATA  = 12'b0001_0000_0000,
        S_UNION      = 12'b0010_0000_0000,
        S_RANK       = 12'b0100_0000_0000,
        S_DONE       = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   side_reg, side_next;

    // state and endpoint side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT_CLEAR;
            side_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
        end
    end

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        cmd.op     = ufst_pkg::OP_NONE;
        cmd.side   = side_reg;
        in_ready   = 1'b0;

        case (state_reg)
            S_BOOT_CLEAR:
            begin
                cmd.op = ufst_pkg::OP_CLEAR_STEP;
                if (status.clear_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = ufst_pkg::OP_CAPTURE;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (status.new_run && status.epoch_full)
                begin
                    cmd.op     = ufst_pkg::OP_CLEAR_START;
                    state_next = S_RUN_CLEAR;
                end
                else
                begin
                    if (status.new_run)
                        cmd.op = ufst_pkg::OP_NEW_EPOCH;
                    state_next = S_CHECK;
                end
            end
            S_RUN_CLEAR:
            begin
                cmd.op = ufst_pkg::OP_CLEAR_STEP;
                if (status.clear_last)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.range_err)
                    state_next = S_DONE;
                else
                begin
                    cmd.op     = ufst_pkg::OP_START_A;
                    side_next  = 1'b0;
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                cmd.op     = ufst_pkg::OP_READ;
                state_next = S_FIND_DATA;
            end
            S_FIND_DATA:
            begin
                if (status.rd_is_root)
                begin
                    cmd.op     = ufst_pkg::OP_ROOT_FOUND;
                    state_next = S_COMP_RD;
                end
                else
                begin
                    cmd.op     = ufst_pkg::OP_FIND_NEXT;
                    state_next = S_FIND_RD;
                end
            end
            S_COMP_RD:
            begin
                if (status.at_root)
                begin
                    if (!side_reg)
                    begin
                        cmd.op     = ufst_pkg::OP_START_B;
                        side_next  = 1'b1;
                        state_next = S_FIND_RD;
                    end
                    else
                        state_next = S_UNION;
                end
                else
                begin
                    cmd.op     = ufst_pkg::OP_READ;
                    state_next = S_COMP_DATA;
                end
            end
            S_COMP_DATA:
            begin
                cmd.op     = ufst_pkg::OP_COMP_WRITE;
                state_next = S_COMP_RD;
            end
            S_UNION:
            begin
                cmd.op = ufst_pkg::OP_UNION;
                if (status.rank_up)
                    state_next = S_RANK;
                else
                    state_next = S_DONE;
            end
            S_RANK:
            begin
                cmd.op     = ufst_pkg::OP_RANK_UP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.op     = ufst_pkg::OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/ufst_datapath.sv @@
// ----------------------------------------------------------------------------
// ufst_datapath
// Epoch-tagged parent/rank table, walk pointer, root/rank holding
// registers, saturating cost accumulator, config register, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ufst_datapath (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ufst_pkg::ctrl_cmd_t                   cmd,
    output ufst_pkg::dp_status_t                       status,
    // edge payload
    input  wire logic                                  new_run,
    input  wire logic signed [ufst_pkg::WEIGHT_W-1:0]  edge_weight,
    input  wire logic [ufst_pkg::VERTEX_W-1:0]         first_vertex,
    input  wire logic [ufst_pkg::VERTEX_W-1:0]         second_vertex,
    // result channel
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output logic                                       edge_taken,
    output logic signed [ufst_pkg::COST_W-1:0]         total_cost,
    output logic                                       range_error,
    // configuration
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [ufst_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [ufst_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [ufst_pkg::APB_DATA_W-1:0]            prdata
);

    localparam int VW = ufst_pkg::VERTEX_W;
    localparam int CW = ufst_pkg::COST_W;

    // parent/rank table
    ufst_pkg::table_word_t table_mem [ufst_pkg::NUM_VERTICES];
    ufst_pkg::table_word_t rd_word_reg;
    ufst_pkg::table_word_t wr_word;
    logic [VW-1:0]         wr_addr;
    logic                  wr_en;
    logic                  rd_en;

    // item and working registers
    logic                              new_run_reg, new_run_next;
    logic [ufst_pkg::WEIGHT_W-1:0]     weight_reg, weight_next;
    logic [VW-1:0]                     vertex_a_reg, vertex_a_next;
    logic [VW-1:0]                     vertex_b_reg, vertex_b_next;
    logic [VW-1:0]                     cur_reg, cur_next;
    logic [VW-1:0]                     root_a_reg, root_a_next;
    logic [VW-1:0]                     root_b_reg, root_b_next;
    logic [ufst_pkg::RANK_W-1:0]       rank_a_reg, rank_a_next;
    logic [ufst_pkg::RANK_W-1:0]       rank_b_reg, rank_b_next;
    logic                              taken_reg, taken_next;
    logic [VW-1:0]                     clear_addr_reg, clear_addr_next;
    logic [ufst_pkg::EPOCH_W-1:0]      epoch_reg, epoch_next;
    logic [CW-1:0]                     cost_reg, cost_next;
    logic [ufst_pkg::COUNT_W-1:0]      vertex_count_reg, vertex_count_next;

    // result register
    logic                              result_valid_reg, result_valid_next;
    logic                              edge_taken_reg, edge_taken_next;
    logic [CW-1:0]                     total_cost_reg, total_cost_next;
    logic                              range_error_reg, range_error_next;

    // derived values
    logic                              rd_hit;
    logic [VW-1:0]                     rd_parent;
    logic [ufst_pkg::RANK_W-1:0]       rd_rank;
    logic [VW-1:0]                     side_root;
    logic [ufst_pkg::COUNT_W-1:0]      limit;
    logic                              range_err;
    logic                              same_root;
    logic [CW:0]                       sum_wide;
    logic [CW-1:0]                     sum_sat;
    logic                              cfg_write;

    // table read and write ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
            table_mem[wr_addr] <= wr_word;
        if (rd_en)
            rd_word_reg <= table_mem[cur_reg];
    end

    // entry from an older run reads as its reset value
    assign rd_hit    = (rd_word_reg.tag == epoch_reg);
    assign rd_parent = rd_hit ? rd_word_reg.parent : cur_reg;
    assign rd_rank   = rd_hit ? rd_word_reg.rank : '0;
    assign side_root = cmd.side ? root_b_reg : root_a_reg;
    assign same_root = (root_a_reg == root_b_reg);

    // endpoint range check against the clamped vertex count
    assign limit     = (vertex_count_reg > ufst_pkg::VERTEX_LIMIT) ?
                       ufst_pkg::VERTEX_LIMIT : vertex_count_reg;
    assign range_err = (ufst_pkg::COUNT_W'(vertex_a_reg) >= limit) ||
                       (ufst_pkg::COUNT_W'(vertex_b_reg) >= limit);

    // saturating cost add
    assign sum_wide = {cost_reg[CW-1], cost_reg} +
                      {{(CW + 1 - ufst_pkg::WEIGHT_W){weight_reg[ufst_pkg::WEIGHT_W-1]}},
                       weight_reg};
    always_comb
    begin
        case (sum_wide[CW:CW-1])
            2'b01:   sum_sat = ufst_pkg::COST_MAX;
            2'b10:   sum_sat = ufst_pkg::COST_MIN;
            default: sum_sat = sum_wide[CW-1:0];
        endcase
    end

    assign cfg_write = psel && penable && pwrite &&
                       (paddr[2] == ufst_pkg::REG_SEL_VERTEX_COUNT);

    // status to controller
    always_comb
    begin
        status.new_run    = new_run_reg;
        status.epoch_full = (epoch_reg == ufst_pkg::EPOCH_MAX);
        status.clear_last = (clear_addr_reg == ufst_pkg::LAST_VERTEX);
        status.range_err  = range_err;
        status.rd_is_root = (rd_parent == cur_reg);
        status.at_root    = (cur_reg == side_root);
        status.rank_up    = !same_root && (rank_a_reg == rank_b_reg) &&
                            (rank_b_reg != ufst_pkg::RANK_MAX);
        status.out_free   = !result_valid_reg || result_ready;
    end

    // next values per operation
    always_comb
    begin
        new_run_next      = new_run_reg;
        weight_next       = weight_reg;
        vertex_a_next     = vertex_a_reg;
        vertex_b_next     = vertex_b_reg;
        cur_next          = cur_reg;
        root_a_next       = root_a_reg;
        root_b_next       = root_b_reg;
        rank_a_next       = rank_a_reg;
        rank_b_next       = rank_b_reg;
        taken_next        = taken_reg;
        clear_addr_next   = clear_addr_reg;
        epoch_next        = epoch_reg;
        cost_next         = cost_reg;
        vertex_count_next = vertex_count_reg;
        result_valid_next = result_valid_reg;
        edge_taken_next   = edge_taken_reg;
        total_cost_next   = total_cost_reg;
        range_error_next  = range_error_reg;
        wr_en             = 1'b0;
        wr_addr           = cur_reg;
        wr_word           = '0;
        rd_en             = 1'b0;

        // result leaves when taken downstream
        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        case (cmd.op)
            ufst_pkg::OP_CAPTURE:
            begin
                new_run_next  = new_run;
                weight_next   = edge_weight;
                vertex_a_next = first_vertex;
                vertex_b_next = second_vertex;
                taken_next    = 1'b0;
            end
            ufst_pkg::OP_NEW_EPOCH:
            begin
                epoch_next = epoch_reg + 1'b1;
                cost_next  = '0;
            end
            ufst_pkg::OP_CLEAR_START:
            begin
                epoch_next      = '0;
                clear_addr_next = '0;
                cost_next       = '0;
            end
            ufst_pkg::OP_CLEAR_STEP:
            begin
                wr_en          = 1'b1;
                wr_addr        = clear_addr_reg;
                wr_word.tag    = epoch_reg;
                wr_word.rank   = '0;
                wr_word.parent = clear_addr_reg;
                if (clear_addr_reg == ufst_pkg::LAST_VERTEX)
                    clear_addr_next = '0;
                else
                    clear_addr_next = clear_addr_reg + 1'b1;
            end
            ufst_pkg::OP_START_A:
            begin
                cur_next = vertex_a_reg;
            end
            ufst_pkg::OP_START_B:
            begin
                cur_next = vertex_b_reg;
            end
            ufst_pkg::OP_READ:
            begin
                rd_en = 1'b1;
            end
            ufst_pkg::OP_FIND_NEXT:
            begin
                cur_next = rd_parent;
            end
            ufst_pkg::OP_ROOT_FOUND:
            begin
                if (cmd.side)
                begin
                    root_b_next = cur_reg;
                    rank_b_next = rd_rank;
                    cur_next    = vertex_b_reg;
                end
                else
                begin
                    root_a_next = cur_reg;
                    rank_a_next = rd_rank;
                    cur_next    = vertex_a_reg;
                end
            end
            ufst_pkg::OP_COMP_WRITE:
            begin
                // point this node straight at the root, then step on
                wr_en          = 1'b1;
                wr_addr        = cur_reg;
                wr_word.tag    = epoch_reg;
                wr_word.rank   = rd_rank;
                wr_word.parent = side_root;
                cur_next       = rd_parent;
            end
            ufst_pkg::OP_UNION:
            begin
                if (!same_root)
                begin
                    taken_next  = 1'b1;
                    cost_next   = sum_sat;
                    wr_en       = 1'b1;
                    wr_word.tag = epoch_reg;
                    if (rank_a_reg > rank_b_reg)
                    begin
                        wr_addr        = root_b_reg;
                        wr_word.rank   = rank_b_reg;
                        wr_word.parent = root_a_reg;
                    end
                    else
                    begin
                        wr_addr        = root_a_reg;
                        wr_word.rank   = rank_a_reg;
                        wr_word.parent = root_b_reg;
                    end
                end
            end
            ufst_pkg::OP_RANK_UP:
            begin
                wr_en          = 1'b1;
                wr_addr        = root_b_reg;
                wr_word.tag    = epoch_reg;
                wr_word.rank   = rank_b_reg + 1'b1;
                wr_word.parent = root_b_reg;
            end
            ufst_pkg::OP_PUBLISH:
            begin
                result_valid_next = 1'b1;
                edge_taken_next   = taken_reg;
                total_cost_next   = cost_reg;
                range_error_next  = range_err;
            end
            default:
            begin
            end
        endcase

        // configuration write
        if (cfg_write)
            vertex_count_next = pwdata[ufst_pkg::COUNT_W-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg   <= '0;
            epoch_reg        <= '0;
            cost_reg         <= '0;
            vertex_count_reg <= ufst_pkg::VERTEX_COUNT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            clear_addr_reg   <= clear_addr_next;
            epoch_reg        <= epoch_next;
            cost_reg         <= cost_next;
            vertex_count_reg <= vertex_count_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        new_run_reg     <= new_run_next;
        weight_reg      <= weight_next;
        vertex_a_reg    <= vertex_a_next;
        vertex_b_reg    <= vertex_b_next;
        cur_reg         <= cur_next;
        root_a_reg      <= root_a_next;
        root_b_reg      <= root_b_next;
        rank_a_reg      <= rank_a_next;
        rank_b_reg      <= rank_b_next;
        taken_reg       <= taken_next;
        edge_taken_reg  <= edge_taken_next;
        total_cost_reg  <= total_cost_next;
        range_error_reg <= range_error_next;
    end

    // outputs
    assign result_valid = result_valid_reg;
    assign edge_taken   = edge_taken_reg;
    assign total_cost   = total_cost_reg;
    assign range_error  = range_error_reg;

    // register read-back
    always_comb
    begin
        if (paddr[2] == ufst_pkg::REG_SEL_VERTEX_COUNT)
            prdata = ufst_pkg::APB_DATA_W'(vertex_count_reg);
        else
            prdata = '0;
    end

endmodule

`default_nettype wire

@@ design/union_find_spanning_tree_cost.sv @@
// ----------------------------------------------------------------------------
// union_find_spanning_tree_cost
// Kruskal spanning forest cost over pre-sorted edges, using a disjoint-set
// table with union by rank and path compression.
//
//   channel   dir   handshake       word
//   edges     in    valid/ready     new_run, edge_weight, first/second_vertex
//   results   out   valid/ready     edge_taken, total_cost, range_error
//   apb       in    psel/penable    vertex_count at byte address 0
//
// Each find reads the table once per node visited and writes it once per
// compressed node; an out-of-range edge skips the finds and the union.
// After reset a clearing pass writes every table entry before the first
// edge is taken. A new run needs no clearing pass, except every 256th,
// which repeats that pass.
// A result waits in the output register; the next edge is taken once the
// result has moved there.
// ----------------------------------------------------------------------------
`default_nettype none

module union_find_spanning_tree_cost (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    ufst_edge_if.sink                                edges,
    ufst_result_if.source                            results,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [ufst_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [ufst_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ufst_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    ufst_pkg::ctrl_cmd_t  cmd;
    ufst_pkg::dp_status_t status;

    // no wait states on the config port
    assign pready = 1'b1;

    // sequencer
    ufst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (edges.valid),
        .in_ready (edges.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, cost and result datapath
    ufst_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .new_run       (edges.new_run),
        .edge_weight   (edges.edge_weight),
        .first_vertex  (edges.first_vertex),
        .second_vertex (edges.second_vertex),
        .result_valid  (results.valid),
        .result_ready  (results.ready),
        .edge_taken    (results.edge_taken),
        .total_cost    (results.total_cost),
        .range_error   (results.range_error),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata)
    );

endmodule

`default_nettype wire
